>>> rtl/core/backward_lzss_decoder_assert.svh
// Assertion macros used by the checker module.
`ifndef BACKWARD_LZSS_DECODER_ASSERT_SVH
`define BACKWARD_LZSS_DECODER_ASSERT_SVH

// Implication checked only outside reset.
`define BLD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked only outside reset.
`define BLD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Next-cycle implication checked at every edge, reset included.
`define BLD_ASSERT_ALL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/bld_pkg.sv
package bld_pkg;

	localparam int HISTORY_DEPTH_DEF = 8192;

	localparam int unsigned BYTE_W   = 8;
	localparam logic [3:0]  FLAG_BITS = 4'd8;
	localparam logic [4:0]  LEN_BASE  = 5'd3;
	localparam logic [12:0] DIST_BASE = 13'd3;

	typedef enum logic {
		ST_TAKE,
		ST_COPY
	} bld_state_t;

	// one write into the output queue
	typedef struct packed {
		logic              vld;
		logic [BYTE_W-1:0] data;
		logic              last;
	} bld_push_t;

endpackage

>>> rtl/core/backward_lzss_decoder.sv
// Channel | Direction | Payload          | Handshake
// in      | input     | in_byte, in_last  | in_valid / in_stall
// out     | output    | out_byte, out_last| out_valid / out_stall
//
// Flag bytes, match high bytes and literals are handled in the transfer that takes them.
// A match low byte is followed by one history read per byte of its length, and
// the input stays stalled until the last read has landed.
// The single read port of the history memory sets the copy rate.
// Reset clears the token state and the write pointer; history is not cleared.
// A two-entry output queue lets copying run on while out_stall is high briefly.
module backward_lzss_decoder #(
	parameter int HISTORY_DEPTH = bld_pkg::HISTORY_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last
);
	import bld_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam logic [AW:0]   DEPTH_W = (AW+1)'(HISTORY_DEPTH);
	localparam logic [AW-1:0] TOP_A   = AW'(HISTORY_DEPTH - 1);

	bld_state_t state_q, state_d;

	logic [7:0]    flags_q, flags_d;
	logic [3:0]    bits_q, bits_d;
	logic          phase_q, phase_d;
	logic [7:0]    high_q, high_d;
	logic [4:0]    left_q, left_d;
	logic          last_q, last_d;
	logic [AW-1:0] rd_ptr_q, rd_ptr_d;
	logic [AW-1:0] wr_ptr_q;

	logic          rd_en;
	logic          rd_s1, rd_last_s1, rd_last_d;
	logic          lit_push;
	logic          in_take, pop, space;
	logic [1:0]    occ;
	logic [2:0]    occ_ahead;
	logic [7:0]    ram_q;
	logic [12:0]   back_dist;
	logic [AW:0]   wr_ext, src_ext;
	bld_push_t     push;

	assign pop       = out_valid && !out_stall;
	assign occ_ahead = {1'b0, occ} + {2'b00, rd_s1} - {2'b00, pop};
	assign space     = (occ_ahead <= 3'd1);
	assign in_stall  = !((state_q == ST_TAKE) && !rd_s1 && space);
	assign in_take   = in_valid && !in_stall;

	// copy source: write pointer minus distance, modulo the history depth
	assign back_dist = {1'b0, high_q[3:0], in_byte} + DIST_BASE;
	assign wr_ext    = {1'b0, wr_ptr_q};
	assign src_ext   = (wr_ext >= {{(AW-12){1'b0}}, back_dist}) ?
		wr_ext - {{(AW-12){1'b0}}, back_dist} :
		wr_ext + DEPTH_W - {{(AW-12){1'b0}}, back_dist};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_TAKE;
			flags_q    <= 8'd0;
			bits_q     <= 4'd0;
			phase_q    <= 1'b0;
			high_q     <= 8'd0;
			left_q     <= 5'd0;
			last_q     <= 1'b0;
			rd_ptr_q   <= '0;
			wr_ptr_q   <= '0;
			rd_s1      <= 1'b0;
			rd_last_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			flags_q    <= flags_d;
			bits_q     <= bits_d;
			phase_q    <= phase_d;
			high_q     <= high_d;
			left_q     <= left_d;
			last_q     <= last_d;
			rd_ptr_q   <= rd_ptr_d;
			rd_s1      <= rd_en;
			rd_last_s1 <= rd_last_d;
			if (push.vld) begin
				wr_ptr_q <= (wr_ptr_q == TOP_A) ? '0 : wr_ptr_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		flags_d   = flags_q;
		bits_d    = bits_q;
		phase_d   = phase_q;
		high_d    = high_q;
		left_d    = left_q;
		last_d    = last_q;
		rd_ptr_d  = rd_ptr_q;
		rd_en     = 1'b0;
		rd_last_d = 1'b0;
		lit_push  = 1'b0;
		case (state_q)
			ST_TAKE: begin
				if (in_take) begin
					if (phase_q) begin
						rd_ptr_d = src_ext[AW-1:0];
						left_d   = {1'b0, high_q[7:4]} + LEN_BASE;
						last_d   = in_last;
						phase_d  = 1'b0;
						state_d  = ST_COPY;
					end else if (bits_q == 4'd0) begin
						flags_d = in_byte;
						bits_d  = FLAG_BITS;
					end else begin
						flags_d = {flags_q[6:0], 1'b0};
						bits_d  = bits_q - 4'd1;
						if (flags_q[7]) begin
							high_d  = in_byte;
							phase_d = 1'b1;
						end else begin
							lit_push = 1'b1;
						end
					end
					// stream end drops unused flag bits and any half match
					if (in_last) begin
						flags_d = 8'd0;
						bits_d  = 4'd0;
						phase_d = 1'b0;
						high_d  = 8'd0;
					end
				end
			end
			ST_COPY: begin
				if (space) begin
					rd_en     = 1'b1;
					rd_ptr_d  = (rd_ptr_q == TOP_A) ? '0 : rd_ptr_q + 1'b1;
					left_d    = left_q - 5'd1;
					rd_last_d = (left_q == 5'd1) && last_q;
					if (left_q == 5'd1) begin
						state_d = ST_TAKE;
					end
				end
			end
			default: begin
				state_d = ST_TAKE;
			end
		endcase
	end

	// input is stalled while read data is in flight, so the write port is free
	always_comb begin
		push.vld  = rd_s1 || lit_push;
		push.data = rd_s1 ? ram_q : in_byte;
		push.last = rd_s1 ? rd_last_s1 : in_last;
	end

	bld_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (push.vld),
		.waddr (wr_ptr_q),
		.wdata (push.data),
		.re    (rd_en),
		.raddr (rd_ptr_q),
		.rdata (ram_q)
	);

	bld_ofifo u_oq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.occ       (occ),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule

>>> rtl/core/bld_ram.sv
module bld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/bld_ofifo.sv
module bld_ofifo (
	input  logic              clk,
	input  logic              arst_n,
	input  bld_pkg::bld_push_t push,
	input  logic              pop,
	output logic [1:0]        occ,
	output logic              out_valid,
	output logic [7:0]        out_byte,
	output logic              out_last
);
	import bld_pkg::*;

	logic [1:0]        occ_q;
	logic [BYTE_W-1:0] data_q [2];
	logic              last_q [2];
	logic [1:0]        slot;

	// slot the new entry lands in, after this cycle's pop
	assign slot = occ_q - {1'b0, pop};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 2'd0;
		end else begin
			occ_q <= occ_q - {1'b0, pop} + {1'b0, push.vld};
		end
	end

	always_ff @(posedge clk) begin
		if (push.vld && (slot == 2'd0)) begin
			data_q[0] <= push.data;
			last_q[0] <= push.last;
		end else if (pop) begin
			data_q[0] <= data_q[1];
			last_q[0] <= last_q[1];
		end
		if (push.vld && (slot != 2'd0)) begin
			data_q[1] <= push.data;
			last_q[1] <= push.last;
		end
	end

	assign occ       = occ_q;
	assign out_valid = (occ_q != 2'd0);
	assign out_byte  = data_q[0];
	assign out_last  = last_q[0];

endmodule

>>> rtl/core/bld_check.sv
`include "backward_lzss_decoder_assert.svh"

module bld_check (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] in_byte,
	input logic       in_last,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       out_last
);

	// a stalled result stays offered
	`BLD_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "out_valid dropped while stalled")

	// a stalled result does not change
	`BLD_ASSERT_NXT(a_out_stable, out_valid && out_stall,
		$stable(out_byte) && $stable(out_last), "out payload changed while stalled")

	// nothing offered on the edge after one seen in reset
	`BLD_ASSERT_ALL(a_rst_quiet, !arst_n, !out_valid, "out_valid high after reset")

	// a result appears only from an input transfer or from a copy that held the input off
	`BLD_ASSERT_IMP(a_out_source, $rose(out_valid),
		$past(in_valid && !in_stall) || $past(in_stall), "result with no source")

endmodule

bind backward_lzss_decoder bld_check u_bld_check (.*);
